### sv/bgd_pkg.sv
// Package for the button gesture dimmer: event codes, register indexes,
// reset values and the colour palette lookup.
// No dependencies.
package bgd_pkg;

   typedef enum logic [2:0] {
      FUNC_SINGLE  = 3'd0,
      FUNC_DOUBLE  = 3'd1,
      FUNC_LONG    = 3'd2,
      FUNC_HOLD    = 3'd3,
      FUNC_RELEASE = 3'd4,
      FUNC_SET     = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      REG_TICKS_PER_STEP = 2'd0,
      REG_STEP_PERCENT   = 2'd1,
      REG_MIN_PERCENT    = 2'd2,
      REG_MAX_PERCENT    = 2'd3
   } reg_index_type;

   localparam logic [7:0] TICKS_PER_STEP_RESET = 8'd12;
   localparam logic [5:0] STEP_PERCENT_RESET   = 6'd2;
   localparam logic [6:0] MIN_PERCENT_RESET    = 7'd5;
   localparam logic [6:0] MAX_PERCENT_RESET    = 7'd100;
   localparam logic [6:0] LEVEL_RESET          = 7'd100;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   function automatic rgb_type palette_rgb(input logic [2:0] ci);
      rgb_type c;
      case (ci)
         3'd0:    c = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
         3'd1:    c = '{red: 8'd0,   green: 8'd255, blue: 8'd0};
         3'd2:    c = '{red: 8'd0,   green: 8'd0,   blue: 8'd255};
         3'd3:    c = '{red: 8'd255, green: 8'd255, blue: 8'd0};
         3'd4:    c = '{red: 8'd255, green: 8'd0,   blue: 8'd255};
         3'd5:    c = '{red: 8'd0,   green: 8'd255, blue: 8'd255};
         3'd6:    c = '{red: 8'd255, green: 8'd128, blue: 8'd0};
         default: c = '{red: 8'd255, green: 8'd255, blue: 8'd255};
      endcase
      return c;
   endfunction

endpackage

### sv/bgd_req_if.sv
// Input channel of the button gesture dimmer: one gesture event per item.
// No dependencies.
interface bgd_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] func;
   logic       set_on;

   modport source (output valid, output func, output set_on, input ready);
   modport sink   (input valid, input func, input set_on, output ready);
endinterface

### sv/bgd_rsp_if.sv
// Result channel of the button gesture dimmer: lamp state after each event.
// No dependencies.
interface bgd_rsp_if;
   logic       valid;
   logic       ready;
   logic       lamp_on;
   logic [6:0] brightness;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic       color_valid;
   logic       dimming_active;

   modport source (output valid, output lamp_on, output brightness, output red,
                   output green, output blue, output color_valid,
                   output dimming_active, input ready);
   modport sink   (input valid, input lamp_on, input brightness, input red,
                   input green, input blue, input color_valid,
                   input dimming_active, output ready);
endinterface

### sv/button_gesture_dimmer_top.sv
// Button gesture dimmer top level: event decode, dimming state and result
// register. Uses bgd_pkg, bgd_req_if and bgd_rsp_if.
//
// Usage:
//   req carries one button event per item (func, set_on), valid/ready.
//   rsp carries one item per event: lamp switch, brightness, palette colour,
//   color_valid and dimming_active as they stand after that event.
//   csr is an APB-style write/read port with four registers at byte
//   addresses 0, 4, 8, 12; pready is always high. Write only while idle.
// Latency: the result of an item is valid the cycle after it is accepted.
// Throughput: one item per cycle while rsp.ready is high; the state update and
//   the result are computed combinationally from the state registers.
// Stall: while a result waits in the output register and rsp.ready is low,
//   req.ready is low; the next item is taken in the cycle the result leaves.
// Reset: synchronous; lamp on at 100 percent, palette entry 0 not chosen,
//   no dimming session, direction down, registers at their defaults.
module button_gesture_dimmer_top #(
   parameter int PALETTE_SIZE = 8
) (
   input  logic              clock,
   input  logic              reset,
   bgd_req_if.sink           req,
   bgd_rsp_if.source         rsp,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [3:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import bgd_pkg::*;

   localparam int IDX_W = $clog2(PALETTE_SIZE);
   localparam logic [IDX_W:0] PAL_LAST = (IDX_W + 1)'(PALETTE_SIZE);

   logic [7:0] ticks_per_step_ff;
   logic [5:0] step_percent_ff;
   logic [6:0] min_percent_ff;
   logic [6:0] max_percent_ff;

   logic             on_flag_ff, on_flag_in;
   logic [IDX_W-1:0] palette_index_ff, palette_index_in;
   logic             palette_chosen_ff, palette_chosen_in;
   logic             dim_active_ff, dim_active_in;
   logic             dim_up_ff, dim_up_in;
   logic [7:0]       hold_ticks_ff, hold_ticks_in;
   logic [6:0]       level_ff, level_in;

   logic       rsp_valid_ff;
   logic       lamp_on_ff;
   logic [6:0] brightness_ff;
   rgb_type    rgb_ff, rgb_in;
   logic       color_valid_ff;
   logic       dimming_active_ff;

   logic             accept;
   logic             csr_write;
   reg_index_type    csr_index;
   logic [IDX_W:0]   index_inc;
   logic [IDX_W+2:0] index_ext;
   logic [7:0]       hold_inc;
   logic [6:0]       level_step;
   logic [7:0]       up_sum;
   logic [7:0]       down_floor;

   assign accept     = req.valid && req.ready;
   assign req.ready  = !rsp_valid_ff || rsp.ready;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      unique case (csr_index)
         REG_TICKS_PER_STEP: csr_prdata = {24'd0, ticks_per_step_ff};
         REG_STEP_PERCENT:   csr_prdata = {26'd0, step_percent_ff};
         REG_MIN_PERCENT:    csr_prdata = {25'd0, min_percent_ff};
         REG_MAX_PERCENT:    csr_prdata = {25'd0, max_percent_ff};
         default:            csr_prdata = 32'd0;
      endcase
   end

   // one dimming step from the current level and direction
   always_comb begin
      up_sum     = {1'b0, level_ff} + {2'b00, step_percent_ff};
      down_floor = {1'b0, min_percent_ff} + {2'b00, step_percent_ff};
      level_step = level_ff;
      if (dim_up_ff) begin
         if (level_ff < max_percent_ff) begin
            if (up_sum >= {1'b0, max_percent_ff}) level_step = max_percent_ff;
            else level_step = up_sum[6:0];
         end
      end else begin
         if (level_ff > min_percent_ff) begin
            if ({1'b0, level_ff} <= down_floor) level_step = min_percent_ff;
            else level_step = level_ff - {1'b0, step_percent_ff};
         end
      end
   end

   always_comb begin
      on_flag_in        = on_flag_ff;
      palette_index_in  = palette_index_ff;
      palette_chosen_in = palette_chosen_ff;
      dim_active_in     = dim_active_ff;
      dim_up_in         = dim_up_ff;
      hold_ticks_in     = hold_ticks_ff;
      level_in          = level_ff;
      index_inc         = {1'b0, palette_index_ff} + (IDX_W + 1)'(1);
      hold_inc          = hold_ticks_ff + 8'd1;
      case (req.func)
         FUNC_SINGLE: on_flag_in = !on_flag_ff;
         FUNC_DOUBLE: begin
            on_flag_in        = 1'b1;
            palette_index_in  = (index_inc >= PAL_LAST) ? '0 : index_inc[IDX_W-1:0];
            palette_chosen_in = 1'b1;
         end
         FUNC_LONG: begin
            dim_active_in = 1'b1;
            hold_ticks_in = 8'd0;
            if (!on_flag_ff) begin
               on_flag_in = 1'b1;
               level_in   = min_percent_ff;
               dim_up_in  = 1'b1;
            end else if (level_ff >= max_percent_ff) begin
               dim_up_in = 1'b0;
            end else if (level_ff <= min_percent_ff) begin
               dim_up_in = 1'b1;
            end
         end
         FUNC_HOLD: begin
            if (dim_active_ff) begin
               if (hold_inc >= ticks_per_step_ff) begin
                  hold_ticks_in = 8'd0;
                  level_in      = level_step;
               end else begin
                  hold_ticks_in = hold_inc;
               end
            end
         end
         FUNC_RELEASE: begin
            if (dim_active_ff) begin
               dim_active_in = 1'b0;
               dim_up_in     = !dim_up_ff;
            end
         end
         FUNC_SET: on_flag_in = req.set_on;
         default: ;
      endcase
      index_ext = {3'b000, palette_index_in};
      rgb_in    = palette_rgb(index_ext[2:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_per_step_ff <= TICKS_PER_STEP_RESET;
         step_percent_ff   <= STEP_PERCENT_RESET;
         min_percent_ff    <= MIN_PERCENT_RESET;
         max_percent_ff    <= MAX_PERCENT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_TICKS_PER_STEP: ticks_per_step_ff <= csr_pwdata[7:0];
            REG_STEP_PERCENT:   step_percent_ff   <= csr_pwdata[5:0];
            REG_MIN_PERCENT:    min_percent_ff    <= csr_pwdata[6:0];
            REG_MAX_PERCENT:    max_percent_ff    <= csr_pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_flag_ff        <= 1'b1;
         palette_index_ff  <= '0;
         palette_chosen_ff <= 1'b0;
         dim_active_ff     <= 1'b0;
         dim_up_ff         <= 1'b0;
         hold_ticks_ff     <= 8'd0;
         level_ff          <= LEVEL_RESET;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (accept) begin
            on_flag_ff        <= on_flag_in;
            palette_index_ff  <= palette_index_in;
            palette_chosen_ff <= palette_chosen_in;
            dim_active_ff     <= dim_active_in;
            dim_up_ff         <= dim_up_in;
            hold_ticks_ff     <= hold_ticks_in;
            level_ff          <= level_in;
            rsp_valid_ff      <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload, loaded with the item
   always_ff @(posedge clock) begin
      if (accept) begin
         lamp_on_ff        <= on_flag_in;
         brightness_ff     <= level_in;
         rgb_ff            <= rgb_in;
         color_valid_ff    <= palette_chosen_in;
         dimming_active_ff <= dim_active_in;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.lamp_on        = lamp_on_ff;
   assign rsp.brightness     = brightness_ff;
   assign rsp.red            = rgb_ff.red;
   assign rsp.green          = rgb_ff.green;
   assign rsp.blue           = rgb_ff.blue;
   assign rsp.color_valid    = color_valid_ff;
   assign rsp.dimming_active = dimming_active_ff;

endmodule

### tb/button_gesture_dimmer_top_tb.sv
// Testbench for button_gesture_dimmer_top: drives gesture events and register writes,
// predicts the lamp state after every event and checks each result item in order.
// Depends on bgd_pkg, bgd_req_if, bgd_rsp_if and button_gesture_dimmer_top.
`timescale 1ns / 1ps

module button_gesture_dimmer_top_tb;
   import bgd_pkg::*;

   localparam logic [2:0] FUNC_SPARE_A = 3'd6;
   localparam logic [2:0] FUNC_SPARE_B = 3'd7;
   localparam int PALETTE_ENTRIES = 8;
   localparam int GESTURE_ROWS = 24;
   localparam int SETTLE_CYCLES = 4;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int WATCHDOG_LIMIT = 4000;

   // entry 0 at the low end, 24'hRRGGBB
   localparam logic [7:0][23:0] COLOUR_TABLE = {
      24'hFFFFFF, 24'hFF8000, 24'h00FFFF, 24'hFF00FF,
      24'hFFFF00, 24'h0000FF, 24'h00FF00, 24'hFF0000};

   typedef struct packed {
      logic       lamp_on;
      logic [6:0] brightness;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       color_valid;
      logic       dimming_active;
   } lamp_result_type;

   typedef struct {
      logic [2:0]      func;
      logic            set_on;
      bit              pinned;
      lamp_result_type want;
   } gesture_row_type;

   localparam lamp_result_type RESET_VIEW = '{lamp_on: 1'b1, brightness: 7'd100,
      red: 8'd255, green: 8'd0, blue: 8'd0, color_valid: 1'b0, dimming_active: 1'b0};
   localparam lamp_result_type OFF_VIEW = '{lamp_on: 1'b0, brightness: 7'd100,
      red: 8'd255, green: 8'd0, blue: 8'd0, color_valid: 1'b0, dimming_active: 1'b0};
   localparam lamp_result_type MIN_START_VIEW = '{lamp_on: 1'b1, brightness: 7'd5,
      red: 8'd255, green: 8'd0, blue: 8'd0, color_valid: 1'b0, dimming_active: 1'b1};
   localparam lamp_result_type NO_VIEW = '0;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   bgd_req_if req_if ();
   bgd_rsp_if rsp_if ();

   button_gesture_dimmer_top #(.PALETTE_SIZE(PALETTE_ENTRIES)) dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predictor copy of registers and state
   logic [7:0] tick_limit;
   logic [5:0] step_size;
   logic [6:0] floor_level;
   logic [6:0] ceil_level;
   logic       lamp_on_q;
   logic [2:0] colour_idx;
   logic       colour_chosen;
   logic       dim_on;
   logic       dim_rising;
   logic [7:0] hold_count;
   logic [6:0] level_q;

   lamp_result_type lamp_expected[$];
   int              mismatch_count = 0;
   int              idle_cycles = 0;
   int              req_idle_pct;
   int              rsp_stall_pct;
   bit              rsp_held;
   bit              req_pinned;
   lamp_result_type req_pinned_view;
   gesture_row_type gesture_rows [GESTURE_ROWS];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic lamp_result_type predict_lamp(input logic [2:0] code,
                                                    input logic set_value);
      lamp_result_type r;
      int nxt;
      int lvl;
      case (code)
         FUNC_SINGLE: lamp_on_q = ~lamp_on_q;
         FUNC_DOUBLE: begin
            lamp_on_q = 1'b1;
            nxt = int'(colour_idx) + 1;
            colour_idx = (nxt >= PALETTE_ENTRIES) ? 3'd0 : nxt[2:0];
            colour_chosen = 1'b1;
         end
         FUNC_LONG: begin
            dim_on = 1'b1;
            hold_count = 8'd0;
            if (!lamp_on_q) begin
               lamp_on_q = 1'b1;
               level_q = floor_level;
               dim_rising = 1'b1;
            end else if (level_q >= ceil_level) begin
               dim_rising = 1'b0;
            end else if (level_q <= floor_level) begin
               dim_rising = 1'b1;
            end
         end
         FUNC_HOLD: begin
            if (dim_on) begin
               hold_count = hold_count + 8'd1;
               if (hold_count >= tick_limit) begin
                  hold_count = 8'd0;
                  lvl = level_q;
                  if (dim_rising) begin
                     if (lvl < ceil_level) begin
                        if (lvl + step_size >= ceil_level) lvl = ceil_level;
                        else lvl = lvl + step_size;
                     end
                  end else if (lvl > floor_level) begin
                     if (lvl <= floor_level + step_size) lvl = floor_level;
                     else lvl = lvl - step_size;
                  end
                  level_q = lvl[6:0];
               end
            end
         end
         FUNC_RELEASE: begin
            if (dim_on) begin
               dim_on = 1'b0;
               dim_rising = ~dim_rising;
            end
         end
         FUNC_SET: lamp_on_q = set_value;
         default: ;
      endcase
      r.lamp_on = lamp_on_q;
      r.brightness = level_q;
      {r.red, r.green, r.blue} = COLOUR_TABLE[colour_idx];
      r.color_valid = colour_chosen;
      r.dimming_active = dim_on;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: mismatch %s: got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : lamp_monitor
      lamp_result_type got;
      lamp_result_type want;
      if (reset) begin
         tick_limit = TICKS_PER_STEP_RESET;
         step_size = STEP_PERCENT_RESET;
         floor_level = MIN_PERCENT_RESET;
         ceil_level = MAX_PERCENT_RESET;
         lamp_on_q = 1'b1;
         colour_idx = 3'd0;
         colour_chosen = 1'b0;
         dim_on = 1'b0;
         dim_rising = 1'b0;
         hold_count = 8'd0;
         level_q = LEVEL_RESET;
         lamp_expected.delete();
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = {rsp_if.lamp_on, rsp_if.brightness, rsp_if.red, rsp_if.green, rsp_if.blue,
                   rsp_if.color_valid, rsp_if.dimming_active};
            if (lamp_expected.size() == 0) begin
               report_mismatch("item with nothing expected", 0, 0);
            end else begin
               want = lamp_expected.pop_front();
               if (got.lamp_on !== want.lamp_on)
                  report_mismatch("lamp_on", int'(got.lamp_on), int'(want.lamp_on));
               if (got.brightness !== want.brightness)
                  report_mismatch("brightness", int'(got.brightness), int'(want.brightness));
               if (got.red !== want.red)
                  report_mismatch("red", int'(got.red), int'(want.red));
               if (got.green !== want.green)
                  report_mismatch("green", int'(got.green), int'(want.green));
               if (got.blue !== want.blue)
                  report_mismatch("blue", int'(got.blue), int'(want.blue));
               if (got.color_valid !== want.color_valid)
                  report_mismatch("color_valid", int'(got.color_valid),
                                  int'(want.color_valid));
               if (got.dimming_active !== want.dimming_active)
                  report_mismatch("dimming_active", int'(got.dimming_active),
                                  int'(want.dimming_active));
            end
         end
         if (req_if.valid && req_if.ready) begin
            want = predict_lamp(req_if.func, req_if.set_on);
            if (req_pinned) want = req_pinned_view;
            lamp_expected.push_back(want);
         end
      end
   end

   always @(posedge clock) begin
      rsp_if.ready <= !rsp_held && ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   task automatic send_event(input logic [2:0] code, input logic set_value, input bit pin,
                             input lamp_result_type view);
      while ($urandom_range(99) < req_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.func <= code;
      req_if.set_on <= set_value;
      req_pinned <= pin;
      req_pinned_view <= view;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic send_random(input logic [2:0] code);
      send_event(code, 1'($urandom_range(1)), 1'b0, NO_VIEW);
   endtask

   // mostly press/hold/release sessions, with stray events mixed in
   task automatic play_gestures(input int count);
      int sent;
      int holds;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(99) < 60) begin
            send_random(FUNC_LONG);
            holds = $urandom_range(0, 40);
            repeat (holds) begin
               if ($urandom_range(19) == 0) send_random(3'($urandom_range(7)));
               else send_random(FUNC_HOLD);
            end
            sent += holds + 1;
            if ($urandom_range(9) != 0) begin
               send_random(FUNC_RELEASE);
               sent++;
            end
         end else begin
            send_random(3'($urandom_range(7)));
            sent++;
         end
      end
   endtask

   task automatic drain;
      @(posedge clock);
      while (lamp_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_TICKS_PER_STEP: tick_limit = value[7:0];
         REG_STEP_PERCENT:   step_size = value[5:0];
         REG_MIN_PERCENT:    floor_level = value[6:0];
         REG_MAX_PERCENT:    ceil_level = value[6:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [7:0] ticks, input logic [5:0] step,
                                 input logic [6:0] lo, input logic [6:0] hi);
      req_if.valid <= 1'b0;
      drain();
      csr_write(REG_TICKS_PER_STEP, {24'd0, ticks});
      csr_write(REG_STEP_PERCENT, {26'd0, step});
      csr_write(REG_MIN_PERCENT, {25'd0, lo});
      csr_write(REG_MAX_PERCENT, {25'd0, hi});
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   initial begin : stimulus
      int row;
      int round;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.func = FUNC_SINGLE;
      req_if.set_on = 1'b0;
      rsp_if.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = 4'd0;
      csr_pwdata = 32'd0;
      rsp_held = 1'b0;
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      req_pinned = 1'b0;
      req_pinned_view = NO_VIEW;
      gesture_rows = '{
         '{FUNC_SPARE_A, 1'b0, 1'b1, RESET_VIEW},
         '{FUNC_SPARE_B, 1'b1, 1'b1, RESET_VIEW},
         '{FUNC_HOLD,    1'b1, 1'b1, RESET_VIEW},
         '{FUNC_RELEASE, 1'b0, 1'b1, RESET_VIEW},
         '{FUNC_SINGLE,  1'b0, 1'b1, OFF_VIEW},
         '{FUNC_SET,     1'b0, 1'b1, OFF_VIEW},
         '{FUNC_SET,     1'b1, 1'b1, RESET_VIEW},
         '{FUNC_SINGLE,  1'b1, 1'b1, OFF_VIEW},
         '{FUNC_LONG,    1'b0, 1'b1, MIN_START_VIEW},
         '{FUNC_HOLD,    1'b0, 1'b0, NO_VIEW},
         '{FUNC_RELEASE, 1'b1, 1'b0, NO_VIEW},
         '{FUNC_LONG,    1'b1, 1'b0, NO_VIEW},
         '{FUNC_HOLD,    1'b0, 1'b0, NO_VIEW},
         '{FUNC_RELEASE, 1'b0, 1'b0, NO_VIEW},
         '{FUNC_DOUBLE,  1'b0, 1'b0, NO_VIEW},
         '{FUNC_DOUBLE,  1'b1, 1'b0, NO_VIEW},
         '{FUNC_DOUBLE,  1'b0, 1'b0, NO_VIEW},
         '{FUNC_DOUBLE,  1'b1, 1'b0, NO_VIEW},
         '{FUNC_DOUBLE,  1'b0, 1'b0, NO_VIEW},
         '{FUNC_DOUBLE,  1'b1, 1'b0, NO_VIEW},
         '{FUNC_DOUBLE,  1'b0, 1'b0, NO_VIEW},
         '{FUNC_DOUBLE,  1'b1, 1'b0, NO_VIEW},
         '{FUNC_SET,     1'b0, 1'b0, NO_VIEW},
         '{FUNC_DOUBLE,  1'b0, 1'b0, NO_VIEW}};

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (row = 0; row < GESTURE_ROWS; row++)
         send_event(gesture_rows[row].func, gesture_rows[row].set_on,
                    gesture_rows[row].pinned, gesture_rows[row].want);

      apply_settings(8'd1, 6'd50, 7'd0, 7'd100);
      play_gestures(220);

      // slowest divider, one long session of holds
      apply_settings(8'd255, 6'd1, 7'd0, 7'd127);
      req_idle_pct = 66;
      send_random(FUNC_LONG);
      repeat (260) send_random(FUNC_HOLD);
      send_random(FUNC_RELEASE);
      play_gestures(150);

      apply_settings(8'd0, 6'd0, 7'd50, 7'd50);
      req_idle_pct = 0;
      rsp_stall_pct = 66;
      play_gestures(220);

      apply_settings(8'd3, 6'd63, 7'd127, 7'd0);
      req_idle_pct = 33;
      rsp_stall_pct = 33;
      play_gestures(220);

      // result side held off while events keep coming
      apply_settings(8'd2, 6'd7, 7'd20, 7'd80);
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      fork
         begin
            rsp_held = 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_held = 1'b0;
         end
      join_none
      play_gestures(40);
      req_if.valid <= 1'b0;
      drain();
      play_gestures(100);

      for (round = 0; round < 3; round++) begin
         apply_settings(8'($urandom_range(0, 15)), 6'($urandom_range(0, 63)),
                        7'($urandom_range(0, 60)), 7'($urandom_range(40, 127)));
         req_idle_pct = (round == 1) ? 0 : 66;
         rsp_stall_pct = (round == 0) ? 0 : 66;
         play_gestures(130);
      end

      req_if.valid <= 1'b0;
      drain();
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
